// ----- src/crsb_pkg.sv -----
`default_nettype none

package crsb_pkg;

  localparam int RowBits = 6;
  localparam int ColBits = 11;

  typedef logic [RowBits-1:0] row_t;
  typedef logic [ColBits-1:0] col_t;

  typedef struct packed {
    col_t        column;
    logic [15:0] prev_top;
    logic [15:0] prev_bottom;
    logic [15:0] cur_top;
    logic [15:0] cur_bottom;
  } col_item_t;

  typedef struct packed {
    row_t               span_row;
    col_t               span_first;
    logic signed [11:0] span_final;
    logic               last_of_run;
  } span_item_t;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_dn;
    row_t row;
    logic wr_en;
    col_t col;
    logic ot_v;
    row_t ot_lo;
    row_t ot_hi;
    logic ob_v;
    row_t ob_lo;
    row_t ob_hi;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/crsb_if.sv -----
`default_nettype none

interface crsb_col_if;
  logic                  valid;
  logic                  ready;
  crsb_pkg::col_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crsb_span_if;
  logic                  valid;
  logic                  ready;
  crsb_pkg::span_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/crsb_cell.sv -----
`default_nettype none

module crsb_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  crsb_pkg::cell_ctl_t  ctl_i,
  input  wire                  tok_lo_i,
  input  wire                  tok_hi_i,
  output logic                 tok_o,
  output crsb_pkg::col_t       rd_o
);
  import crsb_pkg::*;

  localparam row_t MyRow = row_t'(IDX);

  logic tok_q, tok_d;
  col_t start_q;
  logic open_hit;

  always_comb begin
    if (ctl_i.load) begin
      tok_d = (ctl_i.row == MyRow);
    end else if (ctl_i.shift_up) begin
      tok_d = tok_lo_i;
    end else if (ctl_i.shift_dn) begin
      tok_d = tok_hi_i;
    end else begin
      tok_d = tok_q;
    end
  end

  assign open_hit = (ctl_i.ot_v && MyRow >= ctl_i.ot_lo && MyRow <= ctl_i.ot_hi) ||
                    (ctl_i.ob_v && MyRow >= ctl_i.ob_lo && MyRow <= ctl_i.ob_hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && open_hit) begin
      start_q <= ctl_i.col;
    end
  end

  assign tok_o = tok_q;
  assign rd_o  = tok_q ? start_q : '0;

endmodule

`default_nettype wire

// ----- src/crsb_ctrl.sv -----
`default_nettype none

module crsb_ctrl #(
  parameter int ROWS = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  crsb_col_if.sink             col_i,
  crsb_span_if.source          span_o,
  input  crsb_pkg::col_t       rd_start_i,
  output crsb_pkg::cell_ctl_t  ctl_o
);
  import crsb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CT, S_CB, S_WT, S_WB, S_OT, S_OB, S_WR
  } state_e;

  localparam logic signed [17:0] RowsS   = 18'(ROWS);
  localparam logic signed [17:0] RowLast = 18'(ROWS - 1);

  state_e             state_q;
  logic signed [17:0] t1_q, b1_q, t2_q, b2_q;
  col_t               col_q;
  logic               tv_q, bv_q, otv_q, obv_q;
  row_t               tlo_q, thi_q, blo_q, bhi_q, ptr_q;
  row_t               otlo_q, othi_q, oblo_q, obhi_q;
  logic               out_valid_q, out_valid_d;
  span_item_t         out_q;

  logic               c_t, c_b, c_ot, c_ob, bv_now;
  logic signed [17:0] hi_t, lo_b, hi_ot, lo_ob;
  logic               step, walk_end, last;
  span_item_t         emit;

  function automatic row_t clip_row(logic signed [17:0] v);
    row_t r;
    if (v > RowLast) begin
      r = RowLast[RowBits-1:0];
    end else begin
      r = v[RowBits-1:0];
    end
    return r;
  endfunction

  always_comb begin
    c_t    = (t1_q < t2_q) && (t1_q <= b1_q);
    hi_t   = (t2_q - 18'sd1 < b1_q) ? t2_q - 18'sd1 : b1_q;
    c_b    = (b1_q > b2_q) && (b1_q >= t1_q);
    lo_b   = (b2_q + 18'sd1 > t1_q) ? b2_q + 18'sd1 : t1_q;
    bv_now = c_b && (lo_b < RowsS);
    c_ot   = (t2_q < t1_q) && (t2_q <= b2_q);
    hi_ot  = (t1_q - 18'sd1 < b2_q) ? t1_q - 18'sd1 : b2_q;
    c_ob   = (b2_q > b1_q) && (b2_q >= t2_q);
    lo_ob  = (b1_q + 18'sd1 > t2_q) ? b1_q + 18'sd1 : t2_q;
  end

  assign step     = !out_valid_q || span_o.ready;
  assign walk_end = (state_q == S_WT) ? (ptr_q == thi_q) : (ptr_q == blo_q);
  assign last     = (state_q == S_WT) ? (walk_end && !bv_q) : walk_end;

  assign out_valid_d = (step && (state_q inside {S_WT, S_WB})) ||
                       (out_valid_q && !span_o.ready);

  always_comb begin
    emit.span_row    = ptr_q;
    emit.span_first  = rd_start_i;
    emit.span_final  = $signed({1'b0, col_q} - 12'd1);
    emit.last_of_run = last;
  end

  always_comb begin
    ctl_o       = '0;
    ctl_o.col   = col_q;
    ctl_o.ot_v  = otv_q;
    ctl_o.ot_lo = otlo_q;
    ctl_o.ot_hi = othi_q;
    ctl_o.ob_v  = obv_q;
    ctl_o.ob_lo = oblo_q;
    ctl_o.ob_hi = obhi_q;
    case (state_q)
      S_CB: begin
        if (tv_q) begin
          ctl_o.load = 1'b1;
          ctl_o.row  = tlo_q;
        end else if (bv_now) begin
          ctl_o.load = 1'b1;
          ctl_o.row  = clip_row(b1_q);
        end
      end
      S_WT: begin
        if (step) begin
          if (walk_end) begin
            ctl_o.load = bv_q;
            ctl_o.row  = bhi_q;
          end else begin
            ctl_o.shift_up = 1'b1;
          end
        end
      end
      S_WB: begin
        ctl_o.shift_dn = step && !walk_end;
      end
      S_WR: begin
        ctl_o.wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      t1_q        <= '0;
      b1_q        <= '0;
      t2_q        <= '0;
      b2_q        <= '0;
      col_q       <= '0;
      tv_q        <= 1'b0;
      bv_q        <= 1'b0;
      otv_q       <= 1'b0;
      obv_q       <= 1'b0;
      tlo_q       <= '0;
      thi_q       <= '0;
      blo_q       <= '0;
      bhi_q       <= '0;
      ptr_q       <= '0;
      otlo_q      <= '0;
      othi_q      <= '0;
      oblo_q      <= '0;
      obhi_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (col_i.valid) begin
            col_q   <= col_i.data.column;
            t1_q    <= $signed({2'b00, col_i.data.prev_top});
            b1_q    <= $signed({2'b00, col_i.data.prev_bottom});
            t2_q    <= $signed({2'b00, col_i.data.cur_top});
            b2_q    <= $signed({2'b00, col_i.data.cur_bottom});
            state_q <= S_CT;
          end
        end
        S_CT: begin
          tv_q  <= c_t && (t1_q < RowsS);
          tlo_q <= t1_q[RowBits-1:0];
          thi_q <= clip_row(hi_t);
          if (c_t) begin
            t1_q <= hi_t + 18'sd1;
          end
          state_q <= S_CB;
        end
        S_CB: begin
          bv_q  <= bv_now;
          blo_q <= lo_b[RowBits-1:0];
          bhi_q <= clip_row(b1_q);
          if (c_b) begin
            b1_q <= lo_b - 18'sd1;
          end
          if (tv_q) begin
            ptr_q   <= tlo_q;
            state_q <= S_WT;
          end else if (bv_now) begin
            ptr_q   <= clip_row(b1_q);
            state_q <= S_WB;
          end else begin
            state_q <= S_OT;
          end
        end
        S_WT: begin
          if (step) begin
            out_q <= emit;
            if (walk_end) begin
              if (bv_q) begin
                ptr_q   <= bhi_q;
                state_q <= S_WB;
              end else begin
                state_q <= S_OT;
              end
            end else begin
              ptr_q <= ptr_q + row_t'(1);
            end
          end
        end
        S_WB: begin
          if (step) begin
            out_q <= emit;
            if (walk_end) begin
              state_q <= S_OT;
            end else begin
              ptr_q <= ptr_q - row_t'(1);
            end
          end
        end
        S_OT: begin
          otv_q  <= c_ot && (t2_q < RowsS);
          otlo_q <= t2_q[RowBits-1:0];
          othi_q <= clip_row(hi_ot);
          if (c_ot) begin
            t2_q <= hi_ot + 18'sd1;
          end
          state_q <= S_OB;
        end
        S_OB: begin
          obv_q   <= c_ob && (lo_ob < RowsS);
          oblo_q  <= lo_ob[RowBits-1:0];
          obhi_q  <= clip_row(b2_q);
          state_q <= S_WR;
        end
        S_WR: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign col_i.ready = (state_q == S_IDLE);
  assign span_o.valid = out_valid_q;
  assign span_o.data  = out_q;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_i.valid && col_i.ready) |=> (state_q == S_CT))
    else $error("accepted column did not start the close phase");

  a_top_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WT) |-> (ptr_q >= tlo_q && ptr_q <= thi_q))
    else $error("top walk left its row range");

  a_bot_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (ptr_q >= blo_q && ptr_q <= bhi_q))
    else $error("bottom walk left its row range");

  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |-> !(ctl_o.shift_up || ctl_o.shift_dn))
    else $error("token load and shift in the same cycle");
`endif

endmodule

`default_nettype wire

// ----- src/column_to_row_span_builder_unit.sv -----
`default_nettype none

// Turns a floor or ceiling region, fed one screen column per transfer as the
// previous and current column's [top, bottom] row intervals, into horizontal
// spans. Rows left uncovered close a span (row, stored start column,
// column - 1), top rows ascending first, then bottom rows descending; the last
// span of a column carries last_of_run. Rows newly covered store the column as
// their start. The closed rows are read one per cycle, unless the span output
// is held by backpressure, by a token walking the chain of row cells, and
// newly opened rows are all written in the same cycle. The next column is
// taken while the last span still waits at the output.
module column_to_row_span_builder_unit #(
  parameter int ROWS = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  crsb_col_if.sink     col_i,
  crsb_span_if.source  span_o
);
  import crsb_pkg::*;

  cell_ctl_t             ctl;
  logic [ROWS-1:0]       tok;
  logic [ROWS+1:0]       tok_ext;
  col_t [ROWS-1:0]       rd;
  col_t                  rd_start;

  assign tok_ext = {1'b0, tok, 1'b0};

  always_comb begin
    rd_start = '0;
    for (int i = 0; i < ROWS; i++) begin
      rd_start = rd_start | rd[i];
    end
  end

  crsb_ctrl #(
    .ROWS (ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .col_i      (col_i),
    .span_o     (span_o),
    .rd_start_i (rd_start),
    .ctl_o      (ctl)
  );

  for (genvar g = 0; g < ROWS; g++) begin : g_cell
    crsb_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .tok_lo_i (tok_ext[g]),
      .tok_hi_i (tok_ext[g+2]),
      .tok_o    (tok[g]),
      .rd_o     (rd[g])
    );
  end

`ifndef SYNTH
  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one row cell holds the read token");
`endif

endmodule

`default_nettype wire
